FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ovu_pkg.sv
// ----------------------------------------------------------------------------
// ovu_pkg
// Constants and helpers for the obstacle velocity update block.
// ----------------------------------------------------------------------------
package ovu_pkg;

   localparam int MAX_OBSTACLES_DEF = 16;

   localparam int IDX_W   = 4;
   localparam int KIND_W  = 2;
   localparam int WORD_W  = 32;
   localparam int CSR_IDX_W = 4;
   localparam int ACC_W   = 40;
   localparam int QUO_W   = 27;
   localparam int GAIN_W  = 12;
   localparam int NUM_W   = 60;
   localparam int DIST_W  = 64;

   localparam logic [GAIN_W-1:0] REPULSE_GAIN = 12'd3277;

   localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_AREA_MIN_X   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AREA_MIN_Y   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AREA_MAX_X   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AREA_MAX_Y   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WALL_MARGIN  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BODY_RADIUS  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_FLOOR  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_CEIL   = 4'd7;

   localparam logic signed [WORD_W-1:0] AREA_MIN_RST = -32'sd655360;
   localparam logic signed [WORD_W-1:0] AREA_MAX_RST = 32'sd655360;
   localparam logic [WORD_W-2:0]        MARGIN_RST   = 31'd0;
   localparam logic [WORD_W-2:0]        RADIUS_RST   = 31'd32768;
   localparam logic signed [WORD_W-1:0] FLOOR_RST    = -32'sd65536;
   localparam logic signed [WORD_W-1:0] CEIL_RST     = 32'sd65536;

   // Sign-extend a Q16.16 word to accumulator width.
   function automatic logic signed [ACC_W-1:0] sext_word(input logic [WORD_W-1:0] v);
      sext_word = $signed({{(ACC_W-WORD_W){v[WORD_W-1]}}, v});
   endfunction

endpackage

FILE: hw/rtl/obstacle_velocity_update.sv
// ----------------------------------------------------------------------------
// obstacle_velocity_update
// Obstacle table with per-request velocity command and pairwise repulsion.
// ----------------------------------------------------------------------------
// Writes and end-of-tick beats finish in idle; a request before the first
// tick goes straight to the output state and returns its noise as command.
// After the first tick a request walks every table entry: it skips absent
// entries and itself, tests the distance, and for a neighbour that repels runs
// the one-quotient-bit-per-cycle divider. One item at a time.
// Reset clears the present bits, the tick flag and loads register defaults;
// the table memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module obstacle_velocity_update #(
   parameter int MAX_OBSTACLES = ovu_pkg::MAX_OBSTACLES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata, lowest bit up: obstacle[3:0], pos_x, pos_y, vel_x, vel_y, noise_x,
   // noise_y (32 bits each), 4 zero pad bits.
   input  logic [199:0] req_tdata,
   // tuser: kind[1:0].
   input  logic [1:0]   req_tuser,
   // Command channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata, lowest bit up: cmd_obstacle[3:0], cmd_vel_x, cmd_vel_y (32 bits
   // each), 4 zero pad bits.
   output logic [71:0]  rsp_tdata,
   // Register write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [3:0]   csr_index,
   input  logic [31:0]  csr_data
);

`include "assert_macros.svh"

   localparam int AW   = $clog2(MAX_OBSTACLES);
   localparam int EW   = 9;
   localparam int WW   = ovu_pkg::WORD_W;
   localparam int AXW  = WW + 1;
   localparam int DVW  = ovu_pkg::DIST_W + ovu_pkg::QUO_W - 1;
   localparam int CW   = $clog2(ovu_pkg::QUO_W);
   localparam logic [AW-1:0] LAST_J = AW'(MAX_OBSTACLES - 1);
   localparam logic [CW-1:0] LAST_C = CW'(ovu_pkg::QUO_W - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SELF, S_RD, S_DIFF, S_SQX, S_SQY, S_TEST, S_DIV, S_ACC, S_NEXT, S_OUT
   } state_type;

   // Configuration registers.
   logic signed [WW-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff, floor_ff, ceil_ff;
   logic [WW-2:0]        margin_ff, radius_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff  <= ovu_pkg::AREA_MIN_RST;
         min_y_ff  <= ovu_pkg::AREA_MIN_RST;
         max_x_ff  <= ovu_pkg::AREA_MAX_RST;
         max_y_ff  <= ovu_pkg::AREA_MAX_RST;
         margin_ff <= ovu_pkg::MARGIN_RST;
         radius_ff <= ovu_pkg::RADIUS_RST;
         floor_ff  <= ovu_pkg::FLOOR_RST;
         ceil_ff   <= ovu_pkg::CEIL_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            ovu_pkg::REG_AREA_MIN_X:  min_x_ff  <= csr_data;
            ovu_pkg::REG_AREA_MIN_Y:  min_y_ff  <= csr_data;
            ovu_pkg::REG_AREA_MAX_X:  max_x_ff  <= csr_data;
            ovu_pkg::REG_AREA_MAX_Y:  max_y_ff  <= csr_data;
            ovu_pkg::REG_WALL_MARGIN: margin_ff <= csr_data[WW-2:0];
            ovu_pkg::REG_BODY_RADIUS: radius_ff <= csr_data[WW-2:0];
            ovu_pkg::REG_SPEED_FLOOR: floor_ff  <= csr_data;
            ovu_pkg::REG_SPEED_CEIL:  ceil_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Input beat fields.
   logic [3:0]    in_obs;
   logic [WW-1:0] in_px, in_py, in_vx, in_vy, in_nx, in_ny;
   logic [EW-1:0] in_obs_ext;
   logic          in_idx_ok;
   logic [AW-1:0] in_addr;

   assign in_obs     = req_tdata[3:0];
   assign in_px      = req_tdata[35:4];
   assign in_py      = req_tdata[67:36];
   assign in_vx      = req_tdata[99:68];
   assign in_vy      = req_tdata[131:100];
   assign in_nx      = req_tdata[163:132];
   assign in_ny      = req_tdata[195:164];
   assign in_obs_ext = EW'(in_obs);
   assign in_idx_ok  = in_obs_ext < EW'(MAX_OBSTACLES);
   assign in_addr    = in_obs_ext[AW-1:0];

   // Table memory: one entry holds {pos_x, pos_y, vel_x, vel_y}.
   logic [4*WW-1:0] mem [MAX_OBSTACLES];
   logic [4*WW-1:0] rdata_ff;
   logic            wr_en, rd_en;
   logic [AW-1:0]   rd_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[in_addr] <= {in_px, in_py, in_vx, in_vy};
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Sequencer registers.
   state_type                    state_ff;
   logic [MAX_OBSTACLES-1:0]     present_ff;
   logic                         tick_done_ff;
   logic [AW-1:0]                j_ff, self_ff;
   logic [3:0]                   obs_ff;
   logic [WW-1:0]                nx_ff, ny_ff, px_ff, py_ff;
   logic signed [ovu_pkg::ACC_W-1:0] acc_x_ff, acc_y_ff;
   logic [2*WW-1:0]              thresh_ff;
   logic [AXW-1:0]               ax_ff, ay_ff;
   logic                         sx_ff, sy_ff;
   logic [2*WW-1:0]              dx2_ff, dy2_ff, dist2_ff;
   logic [ovu_pkg::NUM_W-1:0]    rem_x_ff, rem_y_ff;
   logic [DVW-1:0]               dvs_ff;
   logic [ovu_pkg::QUO_W-1:0]    quo_x_ff, quo_y_ff;
   logic [CW-1:0]                cnt_ff;
   logic                         rsp_valid_ff;
   logic [71:0]                  rsp_data_ff;

   logic            accept;
   logic [WW-1:0]   diam;
   logic            rd_self, rd_other;
   logic [WW-1:0]   r_px, r_py, r_vx, r_vy;
   logic signed [AXW:0] dx_s, dy_s;
   logic            wall_x, wall_y;
   logic [2*WW:0]   dy2_p1;
   logic [2*WW-1:0] room;
   logic [DVW-1:0]  rem_x_ext, rem_y_ext;
   logic            ge_x, ge_y;
   logic            out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign diam       = {radius_ff, 1'b0};
   assign {r_px, r_py, r_vx, r_vy} = rdata_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Memory port use: a write in idle, a self read on a request, other reads in S_RD.
   assign rd_self  = accept && (req_tuser == ovu_pkg::KIND_REQUEST) && in_idx_ok &&
                     present_ff[in_addr] && tick_done_ff;
   assign rd_other = (state_ff == S_RD) && present_ff[j_ff] && (j_ff != self_ff);
   assign rd_en    = rd_self || rd_other;
   assign rd_addr  = rd_self ? in_addr : j_ff;
   assign wr_en    = accept && (req_tuser == ovu_pkg::KIND_WRITE) && in_idx_ok;

   // Exact wall tests at 34 bits: pos < min + margin or pos > max - margin.
   assign wall_x = ($signed({{2{r_px[WW-1]}}, r_px}) <
                    $signed({{2{min_x_ff[WW-1]}}, min_x_ff}) + $signed({3'b000, margin_ff})) ||
                   ($signed({{2{r_px[WW-1]}}, r_px}) >
                    $signed({{2{max_x_ff[WW-1]}}, max_x_ff}) - $signed({3'b000, margin_ff}));
   assign wall_y = ($signed({{2{r_py[WW-1]}}, r_py}) <
                    $signed({{2{min_y_ff[WW-1]}}, min_y_ff}) + $signed({3'b000, margin_ff})) ||
                   ($signed({{2{r_py[WW-1]}}, r_py}) >
                    $signed({{2{max_y_ff[WW-1]}}, max_y_ff}) - $signed({3'b000, margin_ff}));

   assign dx_s = $signed({{2{px_ff[WW-1]}}, px_ff}) - $signed({{2{r_px[WW-1]}}, r_px});
   assign dy_s = $signed({{2{py_ff[WW-1]}}, py_ff}) - $signed({{2{r_py[WW-1]}}, r_py});

   assign dy2_p1 = {1'b0, dy2_ff} + (2*WW+1)'(1);
   assign room   = thresh_ff - dx2_ff;

   assign rem_x_ext = DVW'(rem_x_ff);
   assign rem_y_ext = DVW'(rem_y_ff);
   assign ge_x      = rem_x_ext >= dvs_ff;
   assign ge_y      = rem_y_ext >= dvs_ff;

   function automatic logic [WW-1:0] clamp(input logic signed [ovu_pkg::ACC_W-1:0] v,
                                           input logic signed [WW-1:0] lo,
                                           input logic signed [WW-1:0] hi);
      priority if (v < ovu_pkg::sext_word(lo)) clamp = lo;
      else if (v > ovu_pkg::sext_word(hi))     clamp = hi;
      else                                     clamp = v[WW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         present_ff   <= '0;
         tick_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The output state loads the next beat itself, so the clear is left to it.
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_tuser)
                     ovu_pkg::KIND_WRITE: begin
                        if (in_idx_ok) begin
                           present_ff[in_addr] <= 1'b1;
                        end
                     end
                     ovu_pkg::KIND_REQUEST: begin
                        obs_ff  <= in_obs;
                        self_ff <= in_addr;
                        nx_ff   <= in_nx;
                        ny_ff   <= in_ny;
                        if (in_idx_ok && present_ff[in_addr]) begin
                           if (tick_done_ff) begin
                              state_ff <= S_SELF;
                           end else begin
                              // Before the first tick the noise is the command.
                              acc_x_ff <= ovu_pkg::sext_word(in_nx);
                              acc_y_ff <= ovu_pkg::sext_word(in_ny);
                              state_ff <= S_OUT;
                           end
                        end
                     end
                     ovu_pkg::KIND_TICK: tick_done_ff <= 1'b1;
                     default: ;
                  endcase
               end
            end
            S_SELF: begin
               px_ff     <= r_px;
               py_ff     <= r_py;
               thresh_ff <= diam * diam;
               acc_x_ff  <= wall_x ? -ovu_pkg::sext_word(r_vx)
                                   : ovu_pkg::sext_word(r_vx) + ovu_pkg::sext_word(nx_ff);
               acc_y_ff  <= wall_y ? -ovu_pkg::sext_word(r_vy)
                                   : ovu_pkg::sext_word(r_vy) + ovu_pkg::sext_word(ny_ff);
               j_ff      <= '0;
               state_ff  <= S_RD;
            end
            S_RD: begin
               state_ff <= rd_other ? S_DIFF : S_NEXT;
            end
            S_DIFF: begin
               sx_ff    <= dx_s[AXW];
               sy_ff    <= dy_s[AXW];
               ax_ff    <= dx_s[AXW] ? AXW'(-dx_s) : dx_s[AXW-1:0];
               ay_ff    <= dy_s[AXW] ? AXW'(-dy_s) : dy_s[AXW-1:0];
               state_ff <= S_SQX;
            end
            S_SQX: begin
               if (ax_ff >= {1'b0, diam} || ay_ff >= {1'b0, diam}) begin
                  state_ff <= S_NEXT;
               end else begin
                  dx2_ff   <= ax_ff[WW-1:0] * ax_ff[WW-1:0];
                  state_ff <= S_SQY;
               end
            end
            S_SQY: begin
               dy2_ff   <= ay_ff[WW-1:0] * ay_ff[WW-1:0];
               state_ff <= S_TEST;
            end
            S_TEST: begin
               if (dx2_ff >= thresh_ff || dy2_p1 >= {1'b0, room}) begin
                  state_ff <= S_NEXT;
               end else begin
                  dist2_ff <= dx2_ff + dy2_ff + (2*WW)'(1);
                  dvs_ff   <= {dx2_ff + dy2_ff + (2*WW)'(1), (ovu_pkg::QUO_W-1)'(0)};
                  rem_x_ff <= {(ovu_pkg::GAIN_W+WW)'(ovu_pkg::REPULSE_GAIN * ax_ff[WW-1:0]),
                               16'h0000};
                  rem_y_ff <= {(ovu_pkg::GAIN_W+WW)'(ovu_pkg::REPULSE_GAIN * ay_ff[WW-1:0]),
                               16'h0000};
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               // Restoring division, one quotient bit per cycle for both axes.
               if (ge_x) rem_x_ff <= ovu_pkg::NUM_W'(rem_x_ext - dvs_ff);
               if (ge_y) rem_y_ff <= ovu_pkg::NUM_W'(rem_y_ext - dvs_ff);
               quo_x_ff <= {quo_x_ff[ovu_pkg::QUO_W-2:0], ge_x};
               quo_y_ff <= {quo_y_ff[ovu_pkg::QUO_W-2:0], ge_y};
               dvs_ff   <= dvs_ff >> 1;
               cnt_ff   <= cnt_ff + CW'(1);
               if (cnt_ff == LAST_C) begin
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               acc_x_ff <= sx_ff ? acc_x_ff - $signed(ovu_pkg::ACC_W'(quo_x_ff))
                                 : acc_x_ff + $signed(ovu_pkg::ACC_W'(quo_x_ff));
               acc_y_ff <= sy_ff ? acc_y_ff - $signed(ovu_pkg::ACC_W'(quo_y_ff))
                                 : acc_y_ff + $signed(ovu_pkg::ACC_W'(quo_y_ff));
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (j_ff == LAST_J) begin
                  state_ff <= S_OUT;
               end else begin
                  j_ff     <= j_ff + AW'(1);
                  state_ff <= S_RD;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {4'h0, clamp(acc_y_ff, floor_ff, ceil_ff),
                                   clamp(acc_x_ff, floor_ff, ceil_ff), obs_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_SAME(a_div_nonzero, state_ff == S_DIV, dist2_ff != '0, "division by zero distance")
   `ASSERT_SAME(a_skip_self, state_ff == S_DIFF, j_ff != self_ff, "self used as neighbor")
   `ASSERT_NEXT(a_tick_sets, accept && req_tuser == ovu_pkg::KIND_TICK, tick_done_ff, "tick lost")

endmodule

FILE: dv/ovu_checker.sv
// ----------------------------------------------------------------------------
// ovu_checker
// Watches the request, command and register channels of the obstacle velocity
// update block, predicts each command and compares it field by field.
// ----------------------------------------------------------------------------
module ovu_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [199:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [71:0]  rsp_tdata,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [3:0]   csr_index,
   input  logic [31:0]  csr_data,
   output int           fail_count,
   output int           pending
);

   // Packed from the lowest bit up: obstacle, vel_x, vel_y.
   typedef struct packed {
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_x;
      logic [3:0]         obstacle;
   } command_type;

   command_type cmd_queue[$];

   longint lo_x, lo_y, hi_x, hi_y, margin, radius, floor_v, ceil_v;
   logic signed [31:0] pos_x_tab[16], pos_y_tab[16], vel_x_tab[16], vel_y_tab[16];
   logic [15:0] present_mask;
   logic        tick_seen;

   assign pending = cmd_queue.size();

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic longint clamp_speed(input longint v);
      if (v < floor_v) return floor_v;
      if (ceil_v < v) return ceil_v;
      return v;
   endfunction

   function automatic bit by_wall(input longint p, input longint lo, input longint hi);
      return p < lo + margin || p > hi - margin;
   endfunction

   // Repulsion along one axis: 0.05 * d / dist2, truncated toward zero.
   function automatic longint push_term(input longint d, input longint unsigned d2);
      longint unsigned mag, q;
      mag = d < 0 ? longint'(-d) : longint'(d);
      q = (64'd3277 * mag * 64'd65536) / d2;
      return d < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic command_type steer(input logic [3:0] idx,
                                         input logic signed [31:0] nx,
                                         input logic signed [31:0] ny);
      command_type c;
      longint cx, cy, px, py, dx, dy;
      longint unsigned diam, thresh, ax, ay, dx2, dy2;
      cx = longint'(nx);
      cy = longint'(ny);
      if (tick_seen) begin
         px = longint'(pos_x_tab[idx]);
         py = longint'(pos_y_tab[idx]);
         cx = longint'(vel_x_tab[idx]);
         cy = longint'(vel_y_tab[idx]);
         if (by_wall(px, lo_x, hi_x)) cx = -cx;
         else cx += longint'(nx);
         if (by_wall(py, lo_y, hi_y)) cy = -cy;
         else cy += longint'(ny);
         diam = 2 * radius;
         thresh = diam * diam;
         for (int j = 0; j < 16; j++) begin
            if (!present_mask[j] || j == idx) continue;
            dx = px - longint'(pos_x_tab[j]);
            dy = py - longint'(pos_y_tab[j]);
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            if (ax >= diam || ay >= diam) continue;
            dx2 = ax * ax;
            dy2 = ay * ay;
            if (dx2 >= thresh) continue;
            if (dy2 + 1 >= thresh - dx2) continue;
            cx += push_term(dx, dx2 + dy2 + 1);
            cy += push_term(dy, dx2 + dy2 + 1);
         end
      end
      c.obstacle = idx;
      c.vel_x = 32'(clamp_speed(cx));
      c.vel_y = 32'(clamp_speed(cy));
      return c;
   endfunction

   always @(posedge clock) begin
      command_type got, want;
      logic [3:0] idx;
      if (reset) begin
         lo_x = longint'(ovu_pkg::AREA_MIN_RST);
         lo_y = longint'(ovu_pkg::AREA_MIN_RST);
         hi_x = longint'(ovu_pkg::AREA_MAX_RST);
         hi_y = longint'(ovu_pkg::AREA_MAX_RST);
         margin = longint'(ovu_pkg::MARGIN_RST);
         radius = longint'(ovu_pkg::RADIUS_RST);
         floor_v = longint'(ovu_pkg::FLOOR_RST);
         ceil_v = longint'(ovu_pkg::CEIL_RST);
         present_mask = '0;
         tick_seen = 1'b0;
         cmd_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[67:0];
            if (cmd_queue.size() == 0) begin
               report("command beat with nothing outstanding", longint'(got.obstacle), -1);
            end else begin
               want = cmd_queue.pop_front();
               if (got.obstacle != want.obstacle)
                  report("cmd_obstacle", longint'(got.obstacle), longint'(want.obstacle));
               if (got.vel_x != want.vel_x)
                  report("cmd_vel_x", longint'(got.vel_x), longint'(want.vel_x));
               if (got.vel_y != want.vel_y)
                  report("cmd_vel_y", longint'(got.vel_y), longint'(want.vel_y));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ovu_pkg::REG_AREA_MIN_X:  lo_x = longint'($signed(csr_data));
               ovu_pkg::REG_AREA_MIN_Y:  lo_y = longint'($signed(csr_data));
               ovu_pkg::REG_AREA_MAX_X:  hi_x = longint'($signed(csr_data));
               ovu_pkg::REG_AREA_MAX_Y:  hi_y = longint'($signed(csr_data));
               ovu_pkg::REG_WALL_MARGIN: margin = longint'(csr_data[30:0]);
               ovu_pkg::REG_BODY_RADIUS: radius = longint'(csr_data[30:0]);
               ovu_pkg::REG_SPEED_FLOOR: floor_v = longint'($signed(csr_data));
               ovu_pkg::REG_SPEED_CEIL:  ceil_v = longint'($signed(csr_data));
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            idx = req_tdata[3:0];
            case (req_tuser)
               ovu_pkg::KIND_TICK: tick_seen = 1'b1;
               ovu_pkg::KIND_WRITE: begin
                  pos_x_tab[idx] = req_tdata[35:4];
                  pos_y_tab[idx] = req_tdata[67:36];
                  vel_x_tab[idx] = req_tdata[99:68];
                  vel_y_tab[idx] = req_tdata[131:100];
                  present_mask[idx] = 1'b1;
               end
               ovu_pkg::KIND_REQUEST:
                  if (present_mask[idx])
                     cmd_queue.push_back(steer(idx, req_tdata[163:132], req_tdata[195:164]));
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: dv/obstacle_velocity_update_tb.sv
// ----------------------------------------------------------------------------
// obstacle_velocity_update_tb
// Drives obstacle writes, command requests and tick beats through several
// register settings, with random idling on both sides; a checker module
// predicts every command and counts mismatches.
// ----------------------------------------------------------------------------
module obstacle_velocity_update_tb;

   // A kind the block must ignore, and a register index past the list.
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam logic [3:0] REG_SPARE  = 4'd9;
   // Cycles allowed for a request to walk the whole table, with margin.
   localparam int SETTLE_CYCLES = 800;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_PER_PHASE = 400;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // tdata, lowest bit up: obstacle, pos_x, pos_y, vel_x, vel_y, noise_x, noise_y.
   logic [199:0] req_tdata;
   // tuser: kind.
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // tdata, lowest bit up: cmd_obstacle, cmd_vel_x, cmd_vel_y.
   logic [71:0]  rsp_tdata;
   logic         csr_valid;
   logic         csr_ready;
   logic [3:0]   csr_index;
   logic [31:0]  csr_data;

   int  fail_count;
   int  pending;
   bit  idle_on;
   int  stall_left;
   int  quiet_cycles;
   longint spread;

   obstacle_velocity_update i_dut (.*);

   ovu_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver stalls in random bursts while idling is enabled.
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // The watchdog ends the run when no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("obstacle_velocity_update_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send(input logic [1:0] kind, input logic [3:0] idx,
                       input logic [31:0] px, input logic [31:0] py,
                       input logic [31:0] vx, input logic [31:0] vy,
                       input logic [31:0] nx, input logic [31:0] ny);
      // An idle gap lowers valid first; otherwise valid stays high beat to beat.
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'b0, ny, nx, vy, vx, py, px, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Each write is followed by one cycle with valid low.
   task automatic write_reg(input logic [3:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Lowers valid and lets every outstanding command drain, then lets a long
   // request that may give no command finish its table walk.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(input logic [31:0] lx, input logic [31:0] ly,
                           input logic [31:0] hx, input logic [31:0] hy,
                           input logic [31:0] mg, input logic [31:0] rd,
                           input logic [31:0] fl, input logic [31:0] cl);
      write_reg(ovu_pkg::REG_AREA_MIN_X, lx);
      write_reg(ovu_pkg::REG_AREA_MIN_Y, ly);
      write_reg(ovu_pkg::REG_AREA_MAX_X, hx);
      write_reg(ovu_pkg::REG_AREA_MAX_Y, hy);
      write_reg(ovu_pkg::REG_WALL_MARGIN, mg);
      write_reg(ovu_pkg::REG_BODY_RADIUS, rd);
      write_reg(ovu_pkg::REG_SPEED_FLOOR, fl);
      write_reg(ovu_pkg::REG_SPEED_CEIL, cl);
      // Positions are clustered on a scale of the radius so repulsion fires.
      spread = 3 * longint'(rd[30:0]);
      if (spread < 65536) spread = 65536;
      if (spread > 64'h2000_0000) spread = 64'h2000_0000;
   endtask

   function automatic logic [31:0] near_pos();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return 32'(longint'($urandom_range(0, 32'(2 * spread))) - spread);
   endfunction

   function automatic logic [31:0] rand_speed();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 262144)) - 131072);
   endfunction

   // Mostly table writes and requests with clustered content, some ticks and
   // noise beats that the block ignores.
   task automatic random_phase(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)
            send(ovu_pkg::KIND_WRITE, 4'($urandom_range(0, 15)), near_pos(), near_pos(),
                 rand_speed(), rand_speed(), $urandom, $urandom);
         else if (pick < 92)
            send(ovu_pkg::KIND_REQUEST, 4'($urandom_range(0, 15)), $urandom, $urandom,
                 $urandom, $urandom, rand_speed(), rand_speed());
         else if (pick < 96)
            send(ovu_pkg::KIND_TICK, 4'($urandom), $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
         else
            send(KIND_SPARE, 4'($urandom), $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
      end
   endtask

   initial begin
      reset = 1'b1;
      idle_on = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ovu_pkg::KIND_WRITE;
      csr_valid = 1'b0;
      csr_index = ovu_pkg::REG_AREA_MIN_X;
      csr_data = '0;
      spread = 98304;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset settings. Before the first tick the command is
      // just the noise pair.
      send(ovu_pkg::KIND_REQUEST, 4'd5, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000);
      send(ovu_pkg::KIND_WRITE, 4'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
           32'h7fff_ffff, 0, 0);
      send(ovu_pkg::KIND_REQUEST, 4'd0, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000);
      send(ovu_pkg::KIND_REQUEST, 4'd0, 0, 0, 0, 0, 32'hffff_ffff, 32'h0000_8000);
      send(ovu_pkg::KIND_WRITE, 4'd15, 32'h0000_4000, 32'h0, 32'h0000_1000, 32'hffff_f000,
           $urandom, $urandom);
      send(ovu_pkg::KIND_REQUEST, 4'd15, 0, 0, 0, 0, 0, 0);
      send(KIND_SPARE, 4'd0, 0, 0, 0, 0, 32'hffff_ffff, 32'hffff_ffff);
      send(ovu_pkg::KIND_REQUEST, 4'd7, 0, 0, 0, 0, 0, 0);
      send(ovu_pkg::KIND_TICK, 4'd0, 0, 0, 0, 0, 0, 0);
      send(ovu_pkg::KIND_TICK, 4'd0, 0, 0, 0, 0, 0, 0);
      // Obstacle 0 sits on a wall, so both axes are reflected.
      send(ovu_pkg::KIND_REQUEST, 4'd0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000);
      // Obstacles 1, 2 and 15 lie within one diameter and push apart.
      send(ovu_pkg::KIND_WRITE, 4'd1, 32'h0000_2000, 32'h0000_0001, 0, 0, 0, 0);
      send(ovu_pkg::KIND_WRITE, 4'd2, 32'h0000_4000, 32'hffff_f000, 32'h0000_8000, 0, 0, 0);
      send(ovu_pkg::KIND_REQUEST, 4'd1, 0, 0, 0, 0, 32'h0000_0100, 32'hffff_ff00);
      send(ovu_pkg::KIND_REQUEST, 4'd15, 0, 0, 0, 0, 0, 0);
      send(ovu_pkg::KIND_REQUEST, 4'd2, 0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
      drain();

      // A bounded area, a small margin and a unit radius, then a spare register write and random traffic.
      set_regs(32'hfff0_0000, 32'hffe0_0000, 32'h0010_0000, 32'h0020_0000,
               32'h0000_4000, 32'h0001_0000, 32'hfffe_0000, 32'h0002_0000);
      write_reg(REG_SPARE, $urandom);
      random_phase(RANDOM_PER_PHASE);
      drain();

      // Extremes: the widest area, a margin that leaves only raw positions -1 and 0 off
      // the walls, the largest radius and the widest speed range.
      set_regs(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      random_phase(RANDOM_PER_PHASE);
      drain();

      // Floor above ceiling, no margin and a zero radius, so nothing repels.
      set_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
               32'h0, 32'h0, 32'h0001_0000, 32'hffff_0000);
      random_phase(RANDOM_PER_PHASE);
      drain();

      set_regs($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 32'h0004_0000),
               $urandom_range(0, 32'h0004_0000), 32'hfffc_0000, 32'h0004_0000);
      random_phase(RANDOM_PER_PHASE);
      drain();

      // The last part runs with no idling on either side.
      set_regs(32'hfff6_0000, 32'hfff6_0000, 32'h000a_0000, 32'h000a_0000,
               32'h0001_0000, 32'h0000_8000, 32'hffff_0000, 32'h0001_0000);
      idle_on = 1'b0;
      random_phase(RANDOM_PER_PHASE);
      drain();

      if (fail_count == 0 && pending == 0)
         $display("obstacle_velocity_update_tb passed");
      else
         $display("obstacle_velocity_update_tb failed");
      $finish;
   end

endmodule
